>>> sv/tvalu_pkg.sv
// Shared types, constants and helpers for the four-lane tuple vector ALU.
package tvalu_pkg;

   localparam int LANES       = 4;
   localparam int DATA_W      = 32;
   localparam int PROD_W      = 64;
   localparam int WIDE_W      = 66;
   localparam int RAD_W       = 65;
   localparam int ROOT_W      = 33;
   localparam int SQRT_STEPS  = 32;
   localparam int DIV_STEPS   = 32;
   localparam int DEPTH_W     = 15;
   localparam int ADDR_W      = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CROSS_LANES = 3;
   localparam int PIPE_DEPTH  = 3 + SQRT_STEPS + DIV_STEPS + 1;

   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 15'd255;
   localparam logic REG_COLOR_DEPTH = 1'b0;

   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

   // Cross product lane i is a[CROSS_I]*b[CROSS_J] - a[CROSS_J]*b[CROSS_I].
   localparam int CROSS_I [CROSS_LANES] = '{1, 2, 0};
   localparam int CROSS_J [CROSS_LANES] = '{2, 0, 1};

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_NEG      = 4'd2,
      OP_SCALE    = 4'd3,
      OP_DIV      = 4'd4,
      OP_MAG      = 4'd5,
      OP_NORM     = 4'd6,
      OP_DOT      = 4'd7,
      OP_CROSS    = 4'd8,
      OP_HADAMARD = 4'd9,
      OP_CLAMP    = 4'd10
   } opcode_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     fault;
   } sat_type;

   function automatic sat_type saturate(input logic signed [WIDE_W-1:0] v);
      sat_type res;
      if (v > WIDE_W'(SAT_MAX)) begin
         res.value = SAT_MAX;
         res.fault = 1'b1;
      end else if (v < WIDE_W'(SAT_MIN)) begin
         res.value = SAT_MIN;
         res.fault = 1'b1;
      end else begin
         res.value = v[DATA_W-1:0];
         res.fault = 1'b0;
      end
      return res;
   endfunction

endpackage

>>> sv/tvalu_lane.sv
// One ALU lane: operand select, two multipliers and the per-component result.
module tvalu_lane
   import tvalu_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  opcode_type               op,
   input  logic signed [DATA_W-1:0] a,
   input  logic signed [DATA_W-1:0] b,
   input  logic signed [DATA_W-1:0] c,
   input  logic [DEPTH_W-1:0]       depth,
   input  logic signed [DATA_W-1:0] cross_a1,
   input  logic signed [DATA_W-1:0] cross_b1,
   input  logic signed [DATA_W-1:0] cross_a2,
   input  logic signed [DATA_W-1:0] cross_b2,
   output logic signed [PROD_W-1:0] prod,
   output sat_type                  early
);

   logic signed [DATA_W-1:0] mul_x;
   logic signed [DATA_W:0]   mul_y;
   logic signed [PROD_W-1:0] prod_ff, prod_in, cross_ff, cross_in;
   opcode_type               op_ff;
   logic signed [DATA_W-1:0] a_ff, b_ff;
   logic [DEPTH_W-1:0]       depth_ff;
   logic signed [WIDE_W-1:0] wide, clamp_top, prod_wide;
   sat_type                  early_ff, early_in;

   always_comb begin
      mul_x = a;
      mul_y = (DATA_W+1)'(b);
      case (op) inside
         OP_SCALE: mul_y = (DATA_W+1)'(c);
         OP_CLAMP: mul_y = {{(DATA_W+1-DEPTH_W){1'b0}}, depth};
         OP_MAG, OP_NORM: mul_y = (DATA_W+1)'(a);
         OP_CROSS: begin
            mul_x = cross_a1;
            mul_y = (DATA_W+1)'(cross_b1);
         end
         default: mul_x = a;
      endcase
      prod_in  = mul_x * mul_y;
      cross_in = cross_a2 * cross_b2;
   end

   // Products are exact, so a floor shift of the difference gives the result rounded down.
   always_comb begin
      prod_wide = WIDE_W'(prod_ff);
      clamp_top = WIDE_W'(depth_ff);
      clamp_top = clamp_top <<< FRAC_BITS;
      wide      = '0;
      case (op_ff) inside
         OP_ADD: wide = WIDE_W'(a_ff) + WIDE_W'(b_ff);
         OP_SUB: wide = WIDE_W'(a_ff) - WIDE_W'(b_ff);
         OP_NEG: wide = -WIDE_W'(a_ff);
         OP_SCALE, OP_HADAMARD: wide = prod_wide >>> FRAC_BITS;
         OP_CROSS: wide = (prod_wide - WIDE_W'(cross_ff)) >>> FRAC_BITS;
         OP_CLAMP: begin
            if (prod_wide < 0) begin
               wide = '0;
            end else if (prod_wide > clamp_top) begin
               wide = clamp_top;
            end else begin
               wide = prod_wide;
            end
         end
         default: wide = '0;
      endcase
      early_in = saturate(wide);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_ff    <= op;
         a_ff     <= a;
         b_ff     <= b;
         depth_ff <= depth;
         prod_ff  <= prod_in;
         cross_ff <= cross_in;
         early_ff <= early_in;
      end
   end

   assign prod  = prod_ff;
   assign early = early_ff;

endmodule

>>> sv/tvalu_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module tvalu_isqrt
   import tvalu_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [RAD_W-1:0]  radicand,
   output logic [ROOT_W-1:0] root
);

   logic [ROOT_W-1:0]     rem_ff  [SQRT_STEPS];
   logic [DATA_W-1:0]     root_ff [SQRT_STEPS];
   logic [RAD_W-2:0]      rad_ff  [SQRT_STEPS];
   logic                  big_ff  [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic [ROOT_W-1:0] rem_prev, rem_in;
      logic [DATA_W-1:0] root_prev, root_in;
      logic [RAD_W-2:0]  rad_prev;
      logic              big_prev;
      logic [ROOT_W+1:0] cur;
      logic [ROOT_W:0]   trial;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand[RAD_W-2:0];
         assign big_prev  = radicand[RAD_W-1];
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign big_prev  = big_ff[k-1];
      end

      assign cur   = {rem_prev, rad_prev[RAD_W-2 -: 2]};
      assign trial = {root_prev, 2'b01};

      always_comb begin
         if (cur >= {1'b0, trial}) begin
            rem_in  = ROOT_W'(cur - {1'b0, trial});
            root_in = {root_prev[DATA_W-2:0], 1'b1};
         end else begin
            rem_in  = cur[ROOT_W-1:0];
            root_in = {root_prev[DATA_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= {rad_prev[RAD_W-4:0], 2'b00};
            big_ff[k]  <= big_prev;
         end
      end
   end

   // A sum of squares that reached 2^64 has a root of exactly 2^32.
   assign root = big_ff[SQRT_STEPS-1] ? {1'b1, {DATA_W{1'b0}}}
                                      : {1'b0, root_ff[SQRT_STEPS-1]};

endmodule

>>> sv/tvalu_div.sv
// Pipelined restoring divider: (num << FRAC_BITS) / den, truncated and saturated.
module tvalu_div
   import tvalu_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [DATA_W-1:0] num,
   input  logic [DATA_W:0]          den_mag,
   input  logic                     den_neg,
   output sat_type                  quot
);

   typedef struct packed {
      logic neg;
      logic num_neg;
      logic dz;
      logic ovf;
      logic nz;
   } div_flag_type;

   logic [DATA_W:0]   rem_ff  [DIV_STEPS+1];
   logic [DATA_W-1:0] bits_ff [DIV_STEPS+1];
   logic [DATA_W-1:0] quo_ff  [DIV_STEPS+1];
   logic [DATA_W:0]   den_ff  [DIV_STEPS+1];
   div_flag_type      flag_ff [DIV_STEPS+1];

   logic              num_neg;
   logic [DATA_W-1:0] num_mag, num_lo;
   logic [DATA_W:0]   num_hi;
   div_flag_type      flag_in;
   div_flag_type      flag_out;
   logic [DATA_W-1:0] quo_out;

   // The high part of the shifted numerator seeds the remainder; if it is
   // already at least the divisor, the quotient cannot fit in 32 bits.
   always_comb begin
      num_neg         = num[DATA_W-1];
      num_mag         = num_neg ? DATA_W'(-num) : DATA_W'(num);
      num_hi          = (DATA_W+1)'(num_mag >> (DATA_W - FRAC_BITS));
      num_lo          = DATA_W'(num_mag << FRAC_BITS);
      flag_in.neg     = num_neg ^ den_neg;
      flag_in.num_neg = num_neg;
      flag_in.dz      = (den_mag == '0);
      flag_in.ovf     = (num_hi >= den_mag);
      flag_in.nz      = (num != '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= num_hi;
         bits_ff[0] <= num_lo;
         quo_ff[0]  <= '0;
         den_ff[0]  <= den_mag;
         flag_ff[0] <= flag_in;
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [DATA_W+1:0] cur;
      logic              ge;
      logic [DATA_W:0]   rem_in;

      assign cur    = {rem_ff[k-1], bits_ff[k-1][DATA_W-1]};
      assign ge     = (cur >= {1'b0, den_ff[k-1]});
      assign rem_in = ge ? (DATA_W+1)'(cur - {1'b0, den_ff[k-1]}) : cur[DATA_W:0];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            bits_ff[k] <= {bits_ff[k-1][DATA_W-2:0], 1'b0};
            quo_ff[k]  <= {quo_ff[k-1][DATA_W-2:0], ge};
            den_ff[k]  <= den_ff[k-1];
            flag_ff[k] <= flag_ff[k-1];
         end
      end
   end

   assign flag_out = flag_ff[DIV_STEPS];
   assign quo_out  = quo_ff[DIV_STEPS];

   always_comb begin
      quot.fault = 1'b0;
      quot.value = '0;
      if (flag_out.dz) begin
         quot.fault = 1'b1;
         if (!flag_out.nz) begin
            quot.value = '0;
         end else begin
            quot.value = flag_out.num_neg ? SAT_MIN : SAT_MAX;
         end
      end else if (flag_out.ovf) begin
         quot.fault = 1'b1;
         quot.value = flag_out.neg ? SAT_MIN : SAT_MAX;
      end else if (!flag_out.neg) begin
         if (quo_out[DATA_W-1]) begin
            quot.fault = 1'b1;
            quot.value = SAT_MAX;
         end else begin
            quot.value = quo_out;
         end
      end else begin
         if (quo_out > DATA_W'(SAT_MIN)) begin
            quot.fault = 1'b1;
            quot.value = SAT_MIN;
         end else begin
            quot.value = DATA_W'(-quo_out);
         end
      end
   end

endmodule

>>> sv/four_lane_tuple_vector_alu.sv
// Top level of the four-lane Q16.16 tuple vector ALU.
//
// Items arrive on the req_ channel (opcode, tuples a and b, scalar) and each
// produces exactly one transfer on the rsp_ channel (result tuple, scalar
// result, fault flag), in order. The color_depth register sits at byte
// address 0 of the APB-style port and may be written only while idle.
//
// The datapath is a fixed pipeline: three stages of input capture, lane
// multipliers and lane/merge results, 32 square-root stages, one divider
// setup stage and 32 divider stages, then the result register. A new item
// can be taken every cycle while the output is not stalled; the pipelined
// square root and divider stages set the latency, and every operation travels
// the same path so results keep their order.
//
// When the receiver holds rsp_ready low with a result waiting, the whole
// pipeline freezes and req_ready drops. Reset clears every valid bit and
// returns color_depth to 255; no clearing pass is needed.
module four_lane_tuple_vector_alu
   import tvalu_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [3:0]                   req_opcode,
   input  logic signed [DATA_W-1:0]     req_a_x,
   input  logic signed [DATA_W-1:0]     req_a_y,
   input  logic signed [DATA_W-1:0]     req_a_z,
   input  logic signed [DATA_W-1:0]     req_a_w,
   input  logic signed [DATA_W-1:0]     req_b_x,
   input  logic signed [DATA_W-1:0]     req_b_y,
   input  logic signed [DATA_W-1:0]     req_b_z,
   input  logic signed [DATA_W-1:0]     req_b_w,
   input  logic signed [DATA_W-1:0]     req_scalar_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_W-1:0]     rsp_r_x,
   output logic signed [DATA_W-1:0]     rsp_r_y,
   output logic signed [DATA_W-1:0]     rsp_r_z,
   output logic signed [DATA_W-1:0]     rsp_r_w,
   output logic signed [DATA_W-1:0]     rsp_scalar_out,
   output logic                         rsp_fault,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ADDR_W-1:0]            paddr,
   input  logic [CSR_DATA_W-1:0]        pwdata,
   output logic [CSR_DATA_W-1:0]        prdata,
   output logic                         pready
);

   typedef struct packed {
      opcode_type                     op;
      logic [LANES-1:0][DATA_W-1:0]   a;
      logic [DATA_W-1:0]              c;
      sat_type [LANES-1:0]            r;
      sat_type                        s;
   } side_type;

   typedef struct packed {
      opcode_type                     op;
      sat_type [LANES-1:0]            r;
      sat_type                        s;
      logic [ROOT_W-1:0]              root;
   } tail_type;

   logic                          en;
   logic [PIPE_DEPTH-1:0]         valid_ff, valid_in;
   logic [DEPTH_W-1:0]            depth_ff, depth_in;

   opcode_type                    op1_ff, op2_ff, op3_ff;
   logic [LANES-1:0][DATA_W-1:0]  a1_ff, b1_ff, a2_ff, a3_ff;
   logic [DATA_W-1:0]             c1_ff, c2_ff, c3_ff;
   sat_type                       dot3_ff, dot3_in;
   logic [RAD_W-1:0]              radicand_ff;
   logic signed [WIDE_W-1:0]      prod_sum;

   logic signed [DATA_W-1:0]      xa1 [LANES];
   logic signed [DATA_W-1:0]      xb1 [LANES];
   logic signed [DATA_W-1:0]      xa2 [LANES];
   logic signed [DATA_W-1:0]      xb2 [LANES];
   logic signed [PROD_W-1:0]      prod [LANES];
   sat_type                       early [LANES];
   sat_type                       quot [LANES];

   side_type                      side_in;
   side_type                      side_ff [SQRT_STEPS];
   side_type                      side_out;
   tail_type                      tail_in;
   tail_type                      tail_ff [DIV_STEPS+1];
   tail_type                      tail_out;
   logic [ROOT_W-1:0]             sqrt_root;
   logic [DATA_W:0]               den_mag;
   logic                          den_neg;

   logic                          rsp_valid_ff;
   logic [LANES-1:0][DATA_W-1:0]  rsp_r_ff, rsp_r_in;
   logic [DATA_W-1:0]             rsp_s_ff, rsp_s_in;
   logic                          rsp_fault_ff, rsp_fault_in;

   // The pipeline advances unless a finished result is stalled at the output.
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // Configuration port.
   assign pready = 1'b1;
   always_comb begin
      depth_in = depth_ff;
      if (psel && penable && pwrite && (paddr[ADDR_W-1] == REG_COLOR_DEPTH)) begin
         depth_in = pwdata[DEPTH_W-1:0];
      end
      prdata = '0;
      if (paddr[ADDR_W-1] == REG_COLOR_DEPTH) begin
         prdata = {{(CSR_DATA_W-DEPTH_W){1'b0}}, depth_ff};
      end
   end

   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= DEPTH_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         if (en) begin
            valid_ff     <= valid_in;
            rsp_valid_ff <= valid_ff[PIPE_DEPTH-1];
         end
      end
   end

   // Input capture and the operand pipeline that runs beside the lanes.
   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff      <= opcode_type'(req_opcode);
         a1_ff       <= {req_a_w, req_a_z, req_a_y, req_a_x};
         b1_ff       <= {req_b_w, req_b_z, req_b_y, req_b_x};
         c1_ff       <= req_scalar_in;
         op2_ff      <= op1_ff;
         a2_ff       <= a1_ff;
         c2_ff       <= c1_ff;
         op3_ff      <= op2_ff;
         a3_ff       <= a2_ff;
         c3_ff       <= c2_ff;
         dot3_ff     <= dot3_in;
         radicand_ff <= prod_sum[RAD_W-1:0];
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      if (i < CROSS_LANES) begin : g_cross
         assign xa1[i] = a1_ff[CROSS_I[i]];
         assign xb1[i] = b1_ff[CROSS_J[i]];
         assign xa2[i] = a1_ff[CROSS_J[i]];
         assign xb2[i] = b1_ff[CROSS_I[i]];
      end else begin : g_no_cross
         assign xa1[i] = '0;
         assign xb1[i] = '0;
         assign xa2[i] = '0;
         assign xb2[i] = '0;
      end

      tvalu_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .en       (en),
         .op       (op1_ff),
         .a        (a1_ff[i]),
         .b        (b1_ff[i]),
         .c        (c1_ff),
         .depth    (depth_ff),
         .cross_a1 (xa1[i]),
         .cross_b1 (xb1[i]),
         .cross_a2 (xa2[i]),
         .cross_b2 (xb2[i]),
         .prod     (prod[i]),
         .early    (early[i])
      );

      tvalu_div #(
         .FRAC_BITS (FRAC_BITS)
      ) u_div (
         .clock   (clock),
         .en      (en),
         .num     (side_out.a[i]),
         .den_mag (den_mag),
         .den_neg (den_neg),
         .quot    (quot[i])
      );
   end

   // Merge: dot product and sum of squares both come from the first products.
   always_comb begin
      prod_sum = '0;
      for (int i = 0; i < LANES; i++) begin
         prod_sum = prod_sum + WIDE_W'(prod[i]);
      end
      dot3_in = '0;
      if (op2_ff == OP_DOT) begin
         dot3_in = saturate(prod_sum >>> FRAC_BITS);
      end
   end

   tvalu_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (radicand_ff),
      .root     (sqrt_root)
   );

   always_comb begin
      side_in.op = op3_ff;
      side_in.a  = a3_ff;
      side_in.c  = c3_ff;
      side_in.s  = dot3_ff;
      for (int i = 0; i < LANES; i++) begin
         side_in.r[i] = early[i];
      end
   end

   assign side_out = side_ff[SQRT_STEPS-1];

   // Normalize divides by the magnitude; divide uses the scalar.
   always_comb begin
      if (side_out.op == OP_NORM) begin
         den_mag = sqrt_root;
         den_neg = 1'b0;
      end else begin
         den_mag = {1'b0, side_out.c[DATA_W-1] ? DATA_W'(-side_out.c) : side_out.c};
         den_neg = side_out.c[DATA_W-1];
      end
      tail_in.op   = side_out.op;
      tail_in.r    = side_out.r;
      tail_in.s    = side_out.s;
      tail_in.root = sqrt_root;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < SQRT_STEPS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         tail_ff[0] <= tail_in;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            tail_ff[k] <= tail_ff[k-1];
         end
      end
   end

   assign tail_out = tail_ff[DIV_STEPS];

   always_comb begin
      rsp_r_in     = '0;
      rsp_s_in     = '0;
      rsp_fault_in = 1'b0;
      case (tail_out.op) inside
         OP_ADD, OP_SUB, OP_NEG, OP_SCALE, OP_CROSS, OP_HADAMARD, OP_CLAMP: begin
            for (int i = 0; i < LANES; i++) begin
               rsp_r_in[i]  = tail_out.r[i].value;
               rsp_fault_in = rsp_fault_in | tail_out.r[i].fault;
            end
         end
         OP_DIV, OP_NORM: begin
            for (int i = 0; i < LANES; i++) begin
               rsp_r_in[i]  = quot[i].value;
               rsp_fault_in = rsp_fault_in | quot[i].fault;
            end
         end
         OP_MAG: begin
            if (tail_out.root > ROOT_W'(SAT_MAX)) begin
               rsp_s_in     = SAT_MAX;
               rsp_fault_in = 1'b1;
            end else begin
               rsp_s_in = tail_out.root[DATA_W-1:0];
            end
         end
         OP_DOT: begin
            rsp_s_in     = tail_out.s.value;
            rsp_fault_in = tail_out.s.fault;
         end
         default: rsp_fault_in = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_r_ff     <= rsp_r_in;
         rsp_s_ff     <= rsp_s_in;
         rsp_fault_ff <= rsp_fault_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_r_x        = rsp_r_ff[0];
   assign rsp_r_y        = rsp_r_ff[1];
   assign rsp_r_z        = rsp_r_ff[2];
   assign rsp_r_w        = rsp_r_ff[3];
   assign rsp_scalar_out = rsp_s_ff;
   assign rsp_fault      = rsp_fault_ff;

endmodule

>>> sv/tvalu_checker.sv
// Port-level checks for the tuple vector ALU, bound to the top level.
module tvalu_checker
   import tvalu_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_r_x,
   input logic signed [DATA_W-1:0] rsp_r_y,
   input logic signed [DATA_W-1:0] rsp_r_z,
   input logic signed [DATA_W-1:0] rsp_r_w,
   input logic signed [DATA_W-1:0] rsp_scalar_out,
   input logic                     rsp_fault
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scalar_out) && $stable(rsp_fault))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while the pipeline is frozen");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with no result waiting");

   a_scalar_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_r_x != 0 || rsp_r_y != 0 || rsp_r_z != 0 || rsp_r_w != 0)
      |-> rsp_scalar_out == 0)
      else $error("tuple and scalar results both nonzero");

endmodule

bind four_lane_tuple_vector_alu tvalu_checker u_tvalu_checker (.*);
